// ----- rtl/core/zyz_pkg.sv -----
// Shared types and constants for the ZYZ Euler point transform.
// Holds word layouts, register codes and the quarter-sine coefficients.
// No dependencies.
package zyz_pkg;

  // Coordinate word, signed Q16.16 by default
  typedef logic signed [31:0] coord_t;

  // One rotation matrix entry, Q30 with headroom for the combine sums
  typedef logic signed [32:0] rot_coef_t;
  typedef rot_coef_t [2:0][2:0] rot_mat_t;

  // Input point word
  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } point_t;

  // Result word
  typedef struct packed {
    coord_t moved_x;
    coord_t moved_y;
    coord_t moved_z;
    logic   saturated;
  } moved_t;

  // Configuration write word
  typedef struct packed {
    logic [2:0]  reg_idx;
    logic [31:0] wdata;
  } cfg_t;

  // Register indexes
  typedef enum logic [2:0] {
    REG_ANGLE_PHI   = 3'd0,
    REG_ANGLE_THETA = 3'd1,
    REG_ANGLE_PSI   = 3'd2,
    REG_SHIFT_X     = 3'd3,
    REG_SHIFT_Y     = 3'd4,
    REG_SHIFT_Z     = 3'd5
  } reg_idx_e;

  // Status from the matrix generator
  typedef struct packed {
    logic     busy;
    rot_mat_t rot;
  } rot_stat_t;

  localparam int unsigned TRIG_FRAC = 30;

  // Odd polynomial for sin(pi/2*u), Q30, index = power / 2
  function automatic logic signed [31:0] sin_coef(logic [2:0] k);
    logic signed [31:0] c;
    case (k)
      3'd0:    c = 32'sd1686629713;
      3'd1:    c = -32'sd693598668;
      3'd2:    c = 32'sd85569306;
      3'd3:    c = -32'sd5026995;
      3'd4:    c = 32'sd172272;
      3'd5:    c = -32'sd3864;
      3'd6:    c = 32'sd61;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/zyz_chan_if.sv -----
// Valid/ready channel carrying one word of payload type T.
// Depends on nothing; payload types come from zyz_pkg.
interface zyz_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/zyz_rot_gen.sv -----
// Rotation matrix generator: six sines/cosines by Horner steps, then the
// ZYZ matrix, all on one shared 32x32 multiplier. Depends on zyz_pkg.
module zyz_rot_gen #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0][15:0]    angle_i,
  input  logic                angle_wr_i,
  output zyz_pkg::rot_stat_t  stat_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SQUARE  = 6'b000010,
    ST_HORNER  = 6'b000100,
    ST_FINAL   = 6'b001000,
    ST_PROD    = 6'b010000,
    ST_COMBINE = 6'b100000
  } rg_state_e;

  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS-2:0] QTR_R   = (ANGLE_BITS - 1)'(1) << (ANGLE_BITS - 2);
  localparam logic signed [63:0] TRIG_ONE   = 64'sd1 <<< zyz_pkg::TRIG_FRAC;
  localparam logic signed [63:0] HALF_LSB   = 64'sd1 <<< (zyz_pkg::TRIG_FRAC - 1);
  localparam int unsigned LAST_TRIG = 5;
  localparam int unsigned LAST_PROD = 13;
  localparam int unsigned TOP_COEF  = 5;

  rg_state_e          state_q, state_d;
  logic [2:0]         idx_q, idx_d;
  logic [3:0]         step_q, step_d;
  logic               dirty_q, dirty_d;
  logic signed [31:0] u2_q, u2_d;
  logic signed [31:0] poly_q, poly_d;
  logic signed [31:0] trig_q [6];
  logic signed [31:0] prod_q [14];
  zyz_pkg::rot_mat_t  rot_q;

  logic [15:0]           angle_sel;
  logic [ANGLE_BITS-1:0] a_eff;
  logic [1:0]            quad;
  logic [ANGLE_BITS-2:0] r_fold;
  logic signed [31:0]    u;
  logic signed [31:0]    mul_a, mul_b;
  logic signed [63:0]    mul_p, mul_sh, mul_rnd;
  logic signed [31:0]    sine;

  // Fold the selected angle into one quadrant, scale to Q30
  always_comb begin
    case (idx_q[2:1])
      2'd0:    angle_sel = angle_i[0];
      2'd1:    angle_sel = angle_i[1];
      default: angle_sel = angle_i[2];
    endcase
    a_eff  = ANGLE_BITS'(angle_sel) + (idx_q[0] ? QUARTER : '0);
    quad   = a_eff[ANGLE_BITS-1 -: 2];
    r_fold = {1'b0, a_eff[ANGLE_BITS-3:0]};
    if (quad[0]) begin
      r_fold = QTR_R - r_fold;
    end
    u = $signed(32'(r_fold) << (32 - ANGLE_BITS));
  end

  // Select multiplier operands per step
  always_comb begin
    mul_a = u;
    mul_b = u;
    case (state_q)
      ST_HORNER: begin
        mul_a = poly_q;
        mul_b = u2_q;
      end
      ST_FINAL: begin
        mul_a = poly_q;
        mul_b = u;
      end
      ST_PROD: begin
        case (step_q)
          4'd0:    begin mul_a = trig_q[1]; mul_b = trig_q[3]; end
          4'd1:    begin mul_a = trig_q[0]; mul_b = trig_q[3]; end
          4'd2:    begin mul_a = prod_q[0]; mul_b = trig_q[5]; end
          4'd3:    begin mul_a = trig_q[0]; mul_b = trig_q[4]; end
          4'd4:    begin mul_a = prod_q[0]; mul_b = trig_q[4]; end
          4'd5:    begin mul_a = trig_q[0]; mul_b = trig_q[5]; end
          4'd6:    begin mul_a = trig_q[1]; mul_b = trig_q[2]; end
          4'd7:    begin mul_a = prod_q[1]; mul_b = trig_q[5]; end
          4'd8:    begin mul_a = trig_q[1]; mul_b = trig_q[4]; end
          4'd9:    begin mul_a = prod_q[1]; mul_b = trig_q[4]; end
          4'd10:   begin mul_a = trig_q[1]; mul_b = trig_q[5]; end
          4'd11:   begin mul_a = trig_q[0]; mul_b = trig_q[2]; end
          4'd12:   begin mul_a = trig_q[2]; mul_b = trig_q[5]; end
          default: begin mul_a = trig_q[2]; mul_b = trig_q[4]; end
        endcase
      end
      default: begin
        mul_a = u;
        mul_b = u;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_sh  = mul_p >>> zyz_pkg::TRIG_FRAC;
  assign mul_rnd = (mul_p + HALF_LSB) >>> zyz_pkg::TRIG_FRAC;

  // Clamp the quarter sine and apply the quadrant sign
  always_comb begin
    if (mul_sh < 64'sd0) begin
      sine = '0;
    end else if (mul_sh > TRIG_ONE) begin
      sine = 32'(TRIG_ONE);
    end else begin
      sine = 32'(mul_sh);
    end
    if (quad[1]) begin
      sine = -sine;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    step_d  = step_q;
    u2_d    = u2_q;
    poly_d  = poly_q;
    dirty_d = dirty_q | angle_wr_i;
    case (state_q)
      ST_IDLE: begin
        if (dirty_q) begin
          dirty_d = angle_wr_i;
          idx_d   = '0;
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        u2_d    = 32'(mul_sh);
        poly_d  = zyz_pkg::sin_coef(3'd6);
        step_d  = 4'(TOP_COEF);
        state_d = ST_HORNER;
      end
      ST_HORNER: begin
        poly_d = 32'(mul_sh) + zyz_pkg::sin_coef(step_q[2:0]);
        step_d = step_q - 4'd1;
        if (step_q == '0) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (idx_q == 3'(LAST_TRIG)) begin
          step_d  = '0;
          state_d = ST_PROD;
        end else begin
          idx_d   = idx_q + 3'd1;
          state_d = ST_SQUARE;
        end
      end
      ST_PROD: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'(LAST_PROD)) begin
          state_d = ST_COMBINE;
        end
      end
      ST_COMBINE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      step_q  <= '0;
      dirty_q <= 1'b1;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      dirty_q <= dirty_d;
    end
  end

  // Working values and results
  always_ff @(posedge clk_i) begin
    u2_q   <= u2_d;
    poly_q <= poly_d;
    if (state_q == ST_FINAL) begin
      trig_q[idx_q] <= sine;
    end
    if (state_q == ST_PROD) begin
      prod_q[step_q] <= 32'(mul_rnd);
    end
    if (state_q == ST_COMBINE) begin
      rot_q[0][0] <= 33'(prod_q[2]) - 33'(prod_q[3]);
      rot_q[0][1] <= -33'(prod_q[4]) - 33'(prod_q[5]);
      rot_q[0][2] <= 33'(prod_q[6]);
      rot_q[1][0] <= 33'(prod_q[7]) + 33'(prod_q[8]);
      rot_q[1][1] <= 33'(prod_q[10]) - 33'(prod_q[9]);
      rot_q[1][2] <= 33'(prod_q[11]);
      rot_q[2][0] <= -33'(prod_q[12]);
      rot_q[2][1] <= 33'(prod_q[13]);
      rot_q[2][2] <= 33'(trig_q[3]);
    end
  end

  assign stat_o.busy = dirty_q | (state_q != ST_IDLE);
  assign stat_o.rot  = rot_q;

endmodule

// ----- rtl/core/zyz_xform_pipe.sv -----
// Point datapath: multiply, row sum, round/translate/saturate stages.
// Valid bits travel with each stage. Depends on zyz_pkg.
module zyz_xform_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  zyz_pkg::point_t               s_data_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output zyz_pkg::moved_t               m_data_o,
  input  zyz_pkg::rot_mat_t             rot_i,
  input  zyz_pkg::coord_t [2:0]         shift_i
);

  localparam logic signed [66:0] HALF_LSB = 67'sd1 <<< (zyz_pkg::TRIG_FRAC - 1);
  localparam logic signed [66:0] SAT_MAX  = 67'sd2147483647;
  localparam logic signed [66:0] SAT_MIN  = -67'sd2147483648;

  logic               v1_q, v2_q, v3_q;
  logic               en1, en2, en3;
  logic signed [64:0] prod_q [3][3];
  logic signed [66:0] sum_q [3];
  zyz_pkg::moved_t    out_q;
  zyz_pkg::coord_t    pt [3];
  zyz_pkg::coord_t    res [3];
  logic [2:0]         clip;

  // Advance a stage when the one after it is empty or moving
  assign en3       = !v3_q || m_ready_i;
  assign en2       = !v2_q || en3;
  assign en1       = !v1_q || en2;
  assign s_ready_o = en1;

  assign pt[0] = s_data_i.point_x;
  assign pt[1] = s_data_i.point_y;
  assign pt[2] = s_data_i.point_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage 1: nine products
  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= $signed(rot_i[i][j]) * pt[j];
        end
      end
    end
  end

  // Stage 2: row sums
  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= 67'(prod_q[i][0]) + 67'(prod_q[i][1]) + 67'(prod_q[i][2]);
      end
    end
  end

  // Stage 3: round, translate, saturate
  always_comb begin
    logic signed [66:0] m;
    for (int i = 0; i < 3; i++) begin
      m = ((sum_q[i] + HALF_LSB) >>> zyz_pkg::TRIG_FRAC) + 67'($signed(shift_i[i]));
      clip[i] = 1'b1;
      if (m > SAT_MAX) begin
        res[i] = 32'(SAT_MAX);
      end else if (m < SAT_MIN) begin
        res[i] = 32'(SAT_MIN);
      end else begin
        res[i]  = 32'(m);
        clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      out_q.moved_x   <= res[0];
      out_q.moved_y   <= res[1];
      out_q.moved_z   <= res[2];
      out_q.saturated <= |clip;
    end
  end

  assign m_valid_o = v3_q;
  assign m_data_o  = out_q;

endmodule

// ----- rtl/core/zyz_euler_point_transform.sv -----
// ZYZ Euler rigid point transform, top level: registers, matrix generator
// and point pipeline. Depends on zyz_pkg, zyz_chan_if, zyz_rot_gen, zyz_xform_pipe.
//
// Use: write angles (index 0..2) and translation (3..5) on cfg_i while no
// points are in flight; cfg_i is always ready. Stream points on pnt_i and
// take results on mov_o, one result word per point, in order.
// Each accepted point passes the product, row-sum and output registers in
// order and shows on mov_o from the output register. Throughput: one point
// per cycle, set by the three-stage multiply / sum / round pipeline, while
// mov_o is not stalled and no matrix pass runs. After reset and after every
// angle write the shared-multiplier matrix generator makes one pass (a start
// step, six sines/cosines, 14 products, one combine); pnt_i.ready stays low during it.
// When mov_o stalls, the output register holds its word and the stages
// behind it fill; pnt_i.ready drops only once all three stages are full.
// Reset clears the angle and translation registers to zero.
module zyz_euler_point_transform #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  zyz_chan_if.sink   cfg_i,
  zyz_chan_if.sink   pnt_i,
  zyz_chan_if.source mov_o
);

  logic [2:0][15:0]      angle_q;
  zyz_pkg::coord_t [2:0] shift_q;
  logic                  cfg_fire;
  logic                  angle_wr;
  logic                  pipe_ready;
  zyz_pkg::rot_stat_t    rot_stat;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  // Decode configuration writes
  always_comb begin
    angle_wr = 1'b0;
    case (cfg_i.data.reg_idx)
      zyz_pkg::REG_ANGLE_PHI,
      zyz_pkg::REG_ANGLE_THETA,
      zyz_pkg::REG_ANGLE_PSI: angle_wr = cfg_fire;
      default:                angle_wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      shift_q <= '0;
    end else if (cfg_fire) begin
      case (cfg_i.data.reg_idx)
        zyz_pkg::REG_ANGLE_PHI:   angle_q[0] <= cfg_i.data.wdata[15:0];
        zyz_pkg::REG_ANGLE_THETA: angle_q[1] <= cfg_i.data.wdata[15:0];
        zyz_pkg::REG_ANGLE_PSI:   angle_q[2] <= cfg_i.data.wdata[15:0];
        zyz_pkg::REG_SHIFT_X:     shift_q[0] <= cfg_i.data.wdata;
        zyz_pkg::REG_SHIFT_Y:     shift_q[1] <= cfg_i.data.wdata;
        zyz_pkg::REG_SHIFT_Z:     shift_q[2] <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  zyz_rot_gen #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_rot_gen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .angle_i    (angle_q),
    .angle_wr_i (angle_wr),
    .stat_o     (rot_stat)
  );

  // Hold off points while the matrix is being rebuilt
  assign pnt_i.ready = pipe_ready & ~rot_stat.busy;

  zyz_xform_pipe u_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (pnt_i.valid & ~rot_stat.busy),
    .s_ready_o (pipe_ready),
    .s_data_i  (pnt_i.data),
    .m_valid_o (mov_o.valid),
    .m_ready_i (mov_o.ready),
    .m_data_o  (mov_o.data),
    .rot_i     (rot_stat.rot),
    .shift_i   (shift_q)
  );

endmodule

// ----- rtl/core/zyz_checker.sv -----
// Port-level checks for the point transform, bound to the top level.
// Depends on zyz_pkg and zyz_euler_point_transform.
module zyz_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            cfg_valid_i,
  input logic            cfg_ready_i,
  input zyz_pkg::cfg_t   cfg_data_i,
  input logic            pnt_ready_i,
  input logic            mov_valid_i,
  input logic            mov_ready_i,
  input zyz_pkg::moved_t mov_data_i
);

  // A stalled result word stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mov_valid_i && !mov_ready_i |=> mov_valid_i)
    else $error("result word dropped while stalled");

  // A clip flag means some coordinate sits on a bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mov_valid_i && mov_data_i.saturated |->
      (mov_data_i.moved_x == 32'sh7fffffff) || (mov_data_i.moved_x == 32'sh80000000) ||
      (mov_data_i.moved_y == 32'sh7fffffff) || (mov_data_i.moved_y == 32'sh80000000) ||
      (mov_data_i.moved_z == 32'sh7fffffff) || (mov_data_i.moved_z == 32'sh80000000))
    else $error("saturated set without a clipped coordinate");

  // An angle write drops pnt_i.ready as the matrix rebuild starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_i &&
      ((cfg_data_i.reg_idx == zyz_pkg::REG_ANGLE_PHI) ||
       (cfg_data_i.reg_idx == zyz_pkg::REG_ANGLE_THETA) ||
       (cfg_data_i.reg_idx == zyz_pkg::REG_ANGLE_PSI)) |=> !pnt_ready_i)
    else $error("points accepted right after an angle write");

endmodule

bind zyz_euler_point_transform zyz_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready),
  .cfg_data_i  (cfg_i.data),
  .pnt_ready_i (pnt_i.ready),
  .mov_valid_i (mov_o.valid),
  .mov_ready_i (mov_o.ready),
  .mov_data_i  (mov_o.data)
);
